### hw/rtl/gvcm_pkg.sv
package gvcm_pkg;

    // Field widths of the stream payloads.
    localparam int AXIS_W    = 16;
    localparam int BUTTON_W  = 6;
    localparam int FSTATE_W  = 4;
    localparam int HEADING_W = 16;
    localparam int VEL_W     = 17;
    localparam int YAW_W     = 16;
    localparam int DZ_W      = 17;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 72;

    // Internal datapath widths.
    localparam int XBITS   = 12;
    localparam int VAL_W   = 32;
    localparam int ANG_W   = 25;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = VAL_W + MUL_B_W;
    localparam int STEP_W  = 5;
    localparam int SPEED_W = 4;

    // CORDIC iteration count and the inverse gain split into two 15-bit halves.
    localparam int CORDIC_STEPS = 18;
    localparam int GAIN_SPLIT   = 15;
    localparam int GAIN_SHIFT   = 30;
    localparam logic [MUL_B_W-1:0] INV_GAIN_HI = MUL_B_W'(19898);
    localparam logic [MUL_B_W-1:0] INV_GAIN_LO = MUL_B_W'(15210);

    // Division by ten through a reciprocal that is exact for 20-bit dividends.
    localparam int DIV10_IN_W  = 20;
    localparam int DIV10_SHIFT = 23;
    localparam logic [MUL_B_W-1:0] DIV10_MUL = MUL_B_W'(838861);

    // Speed range in tenths.
    localparam logic [SPEED_W-1:0] SPEED_RESET = 4'd5;
    localparam logic [SPEED_W-1:0] SPEED_MIN   = 4'd1;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 4'd10;

    // Vehicle state codes.
    localparam logic [FSTATE_W-1:0] VSTATE_NEEDS_RESET = 4'd1;
    localparam logic [FSTATE_W-1:0] VSTATE_FLY_LO      = 4'd3;
    localparam logic [FSTATE_W-1:0] VSTATE_FLY_HI      = 4'd8;

    // Button bit positions.
    localparam int BTN_TAKEOFF = 0;
    localparam int BTN_TRIM    = 1;
    localparam int BTN_CAMERA  = 2;
    localparam int BTN_MODE    = 3;
    localparam int BTN_FASTER  = 4;
    localparam int BTN_SLOWER  = 5;

    // Requests raised by one report.
    typedef struct packed {
        logic camera;
        logic trim;
        logic land;
        logic takeoff;
        logic reset;
    } req_t;

    // Arctangent of 2^-i in units of 2^-24 turn.
    function automatic logic [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] r;
        begin
            case (i)
                5'd0:    r = ANG_W'(2097152);
                5'd1:    r = ANG_W'(1238021);
                5'd2:    r = ANG_W'(654136);
                5'd3:    r = ANG_W'(332050);
                5'd4:    r = ANG_W'(166669);
                5'd5:    r = ANG_W'(83416);
                5'd6:    r = ANG_W'(41718);
                5'd7:    r = ANG_W'(20860);
                5'd8:    r = ANG_W'(10430);
                5'd9:    r = ANG_W'(5215);
                5'd10:   r = ANG_W'(2608);
                5'd11:   r = ANG_W'(1304);
                5'd12:   r = ANG_W'(652);
                5'd13:   r = ANG_W'(326);
                5'd14:   r = ANG_W'(163);
                5'd15:   r = ANG_W'(81);
                5'd16:   r = ANG_W'(41);
                5'd17:   r = ANG_W'(20);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

### hw/rtl/gamepad_velocity_command_mapper_top.sv
// Navigation item: taken while idle; it updates vehicle state and heading and gives no result.
// Joystick item while not flying: zero velocities pass through ST_FINISH to the output register.
// Joystick item while flying: two passes per axis through the shared multiplier in ST_SCALE, then
// ST_FINISH, ST_ROT (CORDIC) and ST_GAIN first in heading-relative mode; s_tready only in ST_IDLE.
// Reset (rst_n low, asynchronous) restores speed 5, absolute mode, zero headings, deadzone 0.
module gamepad_velocity_command_mapper_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration: deadzone register.
    input  logic                               cfg_wr_en,
    input  logic [gvcm_pkg::DZ_W-1:0]          cfg_wr_data,
    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // axis_x, axis_y, axis_up, axis_down, axis_yaw, button_bits, flight_state,
    // heading_angle, zero padding
    input  logic [gvcm_pkg::IN_DATA_W-1:0]     s_tdata,
    // command
    input  logic                               s_tuser,
    // Output stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // vel_x, vel_y, vel_z, yaw_rate, reset_request, takeoff_request,
    // land_request, trim_request, camera_toggle_request
    output logic [gvcm_pkg::OUT_DATA_W-1:0]    m_tdata,
    // twist_valid
    output logic                               m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_GAIN,
        ST_SCALE,
        ST_FINISH
    } state_t;

    // Deadzone: a magnitude strictly below the threshold reads zero.
    function automatic logic signed [16:0] dz17(input logic signed [16:0] v,
                                                input logic [16:0] th);
        logic signed [16:0] m;
        begin
            m = (v < 0) ? -v : v;
            return ($unsigned(m) < th) ? 17'sd0 : v;
        end
    endfunction

    // Control and architectural state.
    state_t                             state_reg, state_next;
    logic [gvcm_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [gvcm_pkg::DZ_W-1:0]          deadzone_reg, deadzone_next;
    logic [gvcm_pkg::SPEED_W-1:0]       speed_reg, speed_next;
    logic                               rel_mode_reg, rel_mode_next;
    logic [gvcm_pkg::BUTTON_W-1:0]      prev_btn_reg, prev_btn_next;
    logic [gvcm_pkg::FSTATE_W-1:0]      vstate_reg, vstate_next;
    logic [gvcm_pkg::HEADING_W-1:0]     heading_reg, heading_next;
    logic [gvcm_pkg::HEADING_W-1:0]     basis_reg, basis_next;

    // Datapath registers.
    logic signed [gvcm_pkg::VAL_W-1:0]   vx_reg, vx_next;
    logic signed [gvcm_pkg::VAL_W-1:0]   vy_reg, vy_next;
    logic signed [gvcm_pkg::VAL_W-1:0]   vz_reg, vz_next;
    logic signed [gvcm_pkg::VAL_W-1:0]   vw_reg, vw_next;
    logic signed [gvcm_pkg::ANG_W-1:0]   ang_reg, ang_next;
    logic signed [gvcm_pkg::MUL_P_W-1:0] acc_reg, acc_next;
    gvcm_pkg::req_t                      req_reg, req_next;
    logic                                fly_reg, fly_next;

    // Output register.
    logic                                  m_tvalid_reg, m_tvalid_next;
    logic [gvcm_pkg::OUT_DATA_W-1:0]       m_tdata_reg, m_tdata_next;
    logic                                  m_tuser_reg, m_tuser_next;

    // Shared multiplier.
    logic signed [gvcm_pkg::VAL_W-1:0]   mul_a;
    logic signed [gvcm_pkg::MUL_B_W-1:0] mul_b;
    logic signed [gvcm_pkg::MUL_P_W-1:0] mul_p;

    // Input field views.
    logic signed [15:0]                  in_ax, in_ay, in_up, in_down, in_yaw;
    logic [gvcm_pkg::BUTTON_W-1:0]       in_btn;
    logic [gvcm_pkg::FSTATE_W-1:0]       in_fstate;
    logic [gvcm_pkg::HEADING_W-1:0]      in_heading;

    // Report decoding.
    logic signed [16:0]                  dx, dy, dzv, dw;
    logic [gvcm_pkg::BUTTON_W-1:0]       rise;
    logic                                flying;
    logic                                needs_reset;
    logic [gvcm_pkg::SPEED_W-1:0]        speed_up;
    logic signed [gvcm_pkg::VAL_W-1:0]   x0, y0;
    logic [gvcm_pkg::HEADING_W-1:0]      rot, rot_bias, resid;
    logic [1:0]                          quad;

    // CORDIC, gain and scale working signals.
    logic signed [gvcm_pkg::VAL_W-1:0]   sx, sy;
    logic signed [63:0]                  gain_sum;
    logic signed [gvcm_pkg::VAL_W-1:0]   sel, mag, scaled;
    logic [gvcm_pkg::DIV10_IN_W-1:0]     quot;
    logic                                out_free;

    assign in_ax      = s_tdata[15:0];
    assign in_ay      = s_tdata[31:16];
    assign in_up      = s_tdata[47:32];
    assign in_down    = s_tdata[63:48];
    assign in_yaw     = s_tdata[79:64];
    assign in_btn     = s_tdata[85:80];
    assign in_fstate  = s_tdata[89:86];
    assign in_heading = s_tdata[105:90];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign mul_p = mul_a * mul_b;

    // Report decoding: deadzone, button edges, flying flag and quarter-turn split of the rotation.
    always_comb
    begin
        dx  = dz17(17'(in_ax), deadzone_reg);
        dy  = dz17(17'(in_ay), deadzone_reg);
        dzv = dz17(17'(in_down) - 17'(in_up), deadzone_reg);
        dw  = dz17(17'(in_yaw), deadzone_reg);
        rise = in_btn & ~prev_btn_reg;
        flying = (vstate_reg >= gvcm_pkg::VSTATE_FLY_LO) &&
                 (vstate_reg <= gvcm_pkg::VSTATE_FLY_HI);
        needs_reset = (vstate_reg <= gvcm_pkg::VSTATE_NEEDS_RESET);
        speed_up = (rise[gvcm_pkg::BTN_FASTER] && (speed_reg < gvcm_pkg::SPEED_MAX)) ?
                   speed_reg + 4'd1 : speed_reg;
        rot      = heading_reg - basis_reg;
        rot_bias = rot + 16'd8192;
        quad     = rot_bias[15:14];
        resid    = rot - {quad, 14'b0};
        x0 = {{3{dx[16]}}, dx, 12'b0};
        y0 = {{3{dy[16]}}, dy, 12'b0};
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        deadzone_next = deadzone_reg;
        speed_next    = speed_reg;
        rel_mode_next = rel_mode_reg;
        prev_btn_next = prev_btn_reg;
        vstate_next   = vstate_reg;
        heading_next  = heading_reg;
        basis_next    = basis_reg;
        vx_next       = vx_reg;
        vy_next       = vy_reg;
        vz_next       = vz_reg;
        vw_next       = vw_reg;
        ang_next      = ang_reg;
        acc_next      = acc_reg;
        req_next      = req_reg;
        fly_next      = fly_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mul_a         = '0;
        mul_b         = '0;
        sx            = vx_reg >>> step_reg;
        sy            = vy_reg >>> step_reg;
        gain_sum      = 64'(acc_reg) <<< gvcm_pkg::GAIN_SPLIT;
        quot          = '0;
        scaled        = '0;

        case (step_reg[2:1])
            2'd0:    sel = vx_reg;
            2'd1:    sel = vy_reg;
            2'd2:    sel = vz_reg;
            default: sel = vw_reg;
        endcase
        mag = sel[gvcm_pkg::VAL_W-1] ? -sel : sel;

        if (cfg_wr_en)
        begin
            deadzone_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        // Navigation update.
                        vstate_next  = in_fstate;
                        heading_next = in_heading;
                    end
                    else
                    begin
                        // Joystick report: requests and state changes.
                        req_next = '0;
                        if (rise[gvcm_pkg::BTN_TAKEOFF])
                        begin
                            if (needs_reset)
                                req_next.reset = 1'b1;
                            else if (flying)
                                req_next.land = 1'b1;
                            else
                                req_next.takeoff = 1'b1;
                        end
                        if (rise[gvcm_pkg::BTN_TRIM] && !flying)
                        begin
                            if (needs_reset)
                            begin
                                req_next.reset = 1'b1;
                            end
                            else
                            begin
                                req_next.trim = 1'b1;
                                basis_next    = heading_reg;
                            end
                        end
                        req_next.camera = rise[gvcm_pkg::BTN_CAMERA];
                        rel_mode_next = rel_mode_reg ^ rise[gvcm_pkg::BTN_MODE];
                        if (rise[gvcm_pkg::BTN_SLOWER])
                            speed_next = (speed_up > gvcm_pkg::SPEED_MIN) ?
                                         speed_up - 4'd1 : gvcm_pkg::SPEED_MIN;
                        else
                            speed_next = speed_up;
                        prev_btn_next = in_btn;
                        fly_next      = flying;
                        step_next     = '0;

                        vz_next = {{3{dzv[16]}}, dzv, 12'b0};
                        vw_next = {{3{dw[16]}}, dw, 12'b0};
                        if (!flying)
                        begin
                            vx_next    = '0;
                            vy_next    = '0;
                            vz_next    = '0;
                            vw_next    = '0;
                            state_next = ST_FINISH;
                        end
                        else if (rel_mode_next)
                        begin
                            // Exact quarter-turn rotation, residual angle to the CORDIC.
                            case (quad)
                                2'd0:
                                begin
                                    vx_next = x0;
                                    vy_next = y0;
                                end
                                2'd1:
                                begin
                                    vx_next = y0;
                                    vy_next = -x0;
                                end
                                2'd2:
                                begin
                                    vx_next = -x0;
                                    vy_next = -y0;
                                end
                                default:
                                begin
                                    vx_next = -y0;
                                    vy_next = x0;
                                end
                            endcase
                            ang_next   = {resid[15], resid, 8'b0};
                            state_next = ST_ROT;
                        end
                        else
                        begin
                            vx_next    = x0;
                            vy_next    = y0;
                            state_next = ST_SCALE;
                        end
                    end
                end
            end

            ST_ROT:
            begin
                // One CORDIC micro-rotation per cycle.
                if (!ang_reg[gvcm_pkg::ANG_W-1])
                begin
                    vx_next  = vx_reg + sy;
                    vy_next  = vy_reg - sx;
                    ang_next = ang_reg - $signed(gvcm_pkg::atan_step(step_reg));
                end
                else
                begin
                    vx_next  = vx_reg - sy;
                    vy_next  = vy_reg + sx;
                    ang_next = ang_reg + $signed(gvcm_pkg::atan_step(step_reg));
                end
                if (step_reg == gvcm_pkg::STEP_W'(gvcm_pkg::CORDIC_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_GAIN;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end

            ST_GAIN:
            begin
                // Inverse CORDIC gain: high half first, then low half and floor shift.
                mul_a = step_reg[1] ? vy_reg : vx_reg;
                mul_b = step_reg[0] ? $signed(gvcm_pkg::INV_GAIN_LO) :
                                      $signed(gvcm_pkg::INV_GAIN_HI);
                gain_sum = (64'(acc_reg) <<< gvcm_pkg::GAIN_SPLIT) + 64'(mul_p);
                if (!step_reg[0])
                    acc_next = mul_p;
                else if (step_reg[1])
                    vy_next = gain_sum[gvcm_pkg::GAIN_SHIFT +: gvcm_pkg::VAL_W];
                else
                    vx_next = gain_sum[gvcm_pkg::GAIN_SHIFT +: gvcm_pkg::VAL_W];
                if (step_reg[1:0] == 2'd3)
                begin
                    step_next  = '0;
                    state_next = ST_SCALE;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end

            ST_SCALE:
            begin
                // Magnitude times speed, then by 4096 and by ten, sign restored.
                if (!step_reg[0])
                begin
                    mul_a    = mag;
                    mul_b    = {{(gvcm_pkg::MUL_B_W - gvcm_pkg::SPEED_W){1'b0}}, speed_reg};
                    acc_next = mul_p;
                end
                else
                begin
                    mul_a  = {{(gvcm_pkg::VAL_W - gvcm_pkg::DIV10_IN_W){1'b0}},
                              acc_reg[gvcm_pkg::XBITS +: gvcm_pkg::DIV10_IN_W]};
                    mul_b  = $signed(gvcm_pkg::DIV10_MUL);
                    quot   = mul_p[gvcm_pkg::DIV10_SHIFT +: gvcm_pkg::DIV10_IN_W];
                    scaled = {{(gvcm_pkg::VAL_W - gvcm_pkg::DIV10_IN_W){1'b0}}, quot};
                    if (sel[gvcm_pkg::VAL_W-1])
                        scaled = -scaled;
                    case (step_reg[2:1])
                        2'd0:    vx_next = scaled;
                        2'd1:    vy_next = scaled;
                        2'd2:    vz_next = scaled;
                        default: vw_next = scaled;
                    endcase
                end
                if (step_reg[2:0] == 3'd7)
                begin
                    step_next  = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end

            ST_FINISH:
            begin
                // Hand the result to the output register once it is free.
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = fly_reg;
                    m_tdata_next  = {req_reg.camera, req_reg.trim, req_reg.land,
                                     req_reg.takeoff, req_reg.reset,
                                     vw_reg[gvcm_pkg::YAW_W-1:0],
                                     vz_reg[gvcm_pkg::VEL_W-1:0],
                                     vy_reg[gvcm_pkg::VEL_W-1:0],
                                     vx_reg[gvcm_pkg::VEL_W-1:0]};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            deadzone_reg <= '0;
            speed_reg    <= gvcm_pkg::SPEED_RESET;
            rel_mode_reg <= 1'b0;
            prev_btn_reg <= '0;
            vstate_reg   <= '0;
            heading_reg  <= '0;
            basis_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            deadzone_reg <= deadzone_next;
            speed_reg    <= speed_next;
            rel_mode_reg <= rel_mode_next;
            prev_btn_reg <= prev_btn_next;
            vstate_reg   <= vstate_next;
            heading_reg  <= heading_next;
            basis_reg    <= basis_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        vx_reg      <= vx_next;
        vy_reg      <= vy_next;
        vz_reg      <= vz_next;
        vw_reg      <= vw_next;
        ang_reg     <= ang_next;
        acc_reg     <= acc_next;
        req_reg     <= req_next;
        fly_reg     <= fly_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

`ifndef ASSERT_OFF
    // Speed stays within one to ten tenths.
    assert property (@(posedge clk) disable iff (!rst_n)
        (speed_reg >= gvcm_pkg::SPEED_MIN) && (speed_reg <= gvcm_pkg::SPEED_MAX))
    else $error("speed out of range");

    // A result without twist carries zero velocities.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[66:0] == '0))
    else $error("velocity issued while not flying");

    // Reset, takeoff and land requests exclude one another.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0({m_tdata[67], m_tdata[68], m_tdata[69]}))
    else $error("conflicting flight requests");

    // The CORDIC step count stays within the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROT) |-> (step_reg < gvcm_pkg::STEP_W'(gvcm_pkg::CORDIC_STEPS)))
    else $error("CORDIC step overrun");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT      = 3000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int DIR_ROWS        = 28;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 112;
    localparam longint CORDIC_INV_GAIN = 652032874;

    // Request masks in the bit order of req_t.
    localparam logic [4:0] REQ_NONE    = 5'b00000;
    localparam logic [4:0] REQ_RESET   = 5'b00001;
    localparam logic [4:0] REQ_TAKEOFF = 5'b00010;
    localparam logic [4:0] REQ_LAND    = 5'b00100;
    localparam logic [4:0] REQ_TRIM    = 5'b01000;
    localparam logic [4:0] REQ_CAMERA  = 5'b10000;

    // Gamepad or navigation report, laid out as on s_tdata.
    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] heading;
        logic [3:0]  fstate;
        logic [5:0]  buttons;
        logic [15:0] ayaw;
        logic [15:0] adown;
        logic [15:0] aup;
        logic [15:0] ay;
        logic [15:0] ax;
    } report_t;

    // Velocity command, laid out as on m_tdata.
    typedef struct packed {
        gvcm_pkg::req_t req;
        logic [15:0]    yaw;
        logic [16:0]    vz;
        logic [16:0]    vy;
        logic [16:0]    vx;
    } twist_cmd_t;

    typedef struct packed {
        logic       twist;
        twist_cmd_t cmd;
    } twist_exp_t;

    // One row of the directed stimulus; the command is given where it is obvious.
    typedef struct packed {
        bit         nav;
        int         ax;
        int         ay;
        int         aup;
        int         adown;
        int         ayaw;
        int         btn;
        int         fst;
        int         hdg;
        bit         known;
        bit         twist;
        int         vx;
        int         vy;
        int         vz;
        int         yaw;
        logic [4:0] req;
    } dir_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [gvcm_pkg::DZ_W-1:0]       cfg_wr_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [gvcm_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [gvcm_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tuser;

    // Mirror of the block's state.
    int          speed;
    bit          rel_mode;
    logic [5:0]  prev_btn;
    logic [3:0]  veh_state;
    logic [15:0] veh_heading;
    logic [15:0] basis_heading;
    int          dz_reg;

    twist_exp_t  twist_pending[$];
    logic [5:0]  held_buttons = '0;
    bit          hold_req = 1'b0;
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;

    gamepad_velocity_command_mapper_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Arctangent of 2^-i in units of 2^-24 turn.
    function automatic longint atan_units(input int i);
        case (i)
            0:       return 2097152;
            1:       return 1238021;
            2:       return 654136;
            3:       return 332050;
            4:       return 166669;
            5:       return 83416;
            6:       return 41718;
            7:       return 20860;
            8:       return 10430;
            9:       return 5215;
            10:      return 2608;
            11:      return 1304;
            12:      return 652;
            13:      return 326;
            14:      return 163;
            15:      return 81;
            16:      return 41;
            17:      return 20;
            default: return 0;
        endcase
    endfunction

    function automatic longint dead_band(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        return (m < longint'(dz_reg)) ? 0 : v;
    endfunction

    // Rotate by a binary angle: exact quarter turns first, then CORDIC on the residue.
    function automatic void rotate_by(inout longint px, inout longint py, input logic [15:0] rot);
        longint      x;
        longint      y;
        longint      t;
        longint      ang;
        longint      sx;
        longint      sy;
        logic [1:0]  quad;
        logic [15:0] resid;
        x = px;
        y = py;
        quad = 2'((int'(rot) + 8192) >>> 14);
        case (quad)
            2'd1:
            begin
                t = x;
                x = y;
                y = -t;
            end
            2'd2:
            begin
                x = -x;
                y = -y;
            end
            2'd3:
            begin
                t = x;
                x = -y;
                y = t;
            end
            default:
            begin
            end
        endcase
        resid = rot - {quad, 14'd0};
        ang = longint'($signed(resid)) * 256;
        for (int i = 0; i < gvcm_pkg::CORDIC_STEPS; i++)
        begin
            sx = x >>> i;
            sy = y >>> i;
            if (ang >= 0)
            begin
                x = x + sy;
                y = y - sx;
                ang = ang - atan_units(i);
            end
            else
            begin
                x = x - sy;
                y = y + sx;
                ang = ang + atan_units(i);
            end
        end
        px = (x * CORDIC_INV_GAIN) >>> gvcm_pkg::GAIN_SHIFT;
        py = (y * CORDIC_INV_GAIN) >>> gvcm_pkg::GAIN_SHIFT;
    endfunction

    function automatic longint speed_scale(input longint v);
        return (v * longint'(speed)) / (longint'(10) << gvcm_pkg::XBITS);
    endfunction

    // Work out the command for one report; returns 1 when the block emits one.
    function automatic bit map_report(input bit nav, input report_t r, output twist_exp_t e);
        longint     vx;
        longint     vy;
        longint     vz;
        longint     vw;
        logic [5:0] rise;
        bit         flying;
        e = '0;
        if (nav)
        begin
            veh_state = r.fstate;
            veh_heading = r.heading;
            return 1'b0;
        end
        vx = dead_band(longint'($signed(r.ax)));
        vy = dead_band(longint'($signed(r.ay)));
        vz = dead_band(longint'($signed(r.adown)) - longint'($signed(r.aup)));
        vw = dead_band(longint'($signed(r.ayaw)));
        rise = r.buttons & ~prev_btn;
        flying = (veh_state >= gvcm_pkg::VSTATE_FLY_LO) &&
                 (veh_state <= gvcm_pkg::VSTATE_FLY_HI);

        if (rise[gvcm_pkg::BTN_TAKEOFF])
        begin
            if (veh_state <= gvcm_pkg::VSTATE_NEEDS_RESET)
                e.cmd.req.reset = 1'b1;
            else if (flying)
                e.cmd.req.land = 1'b1;
            else
                e.cmd.req.takeoff = 1'b1;
        end
        if (rise[gvcm_pkg::BTN_TRIM] && !flying)
        begin
            if (veh_state <= gvcm_pkg::VSTATE_NEEDS_RESET)
                e.cmd.req.reset = 1'b1;
            else
            begin
                e.cmd.req.trim = 1'b1;
                basis_heading = veh_heading;
            end
        end
        if (rise[gvcm_pkg::BTN_CAMERA])
            e.cmd.req.camera = 1'b1;
        if (rise[gvcm_pkg::BTN_MODE])
            rel_mode = !rel_mode;
        if (rise[gvcm_pkg::BTN_FASTER] && speed < int'(gvcm_pkg::SPEED_MAX))
            speed = speed + 1;
        if (rise[gvcm_pkg::BTN_SLOWER])
            speed = (speed > int'(gvcm_pkg::SPEED_MIN)) ?
                    speed - 1 : int'(gvcm_pkg::SPEED_MIN);

        if (flying)
        begin
            vx = vx << gvcm_pkg::XBITS;
            vy = vy << gvcm_pkg::XBITS;
            if (rel_mode)
                rotate_by(vx, vy, veh_heading - basis_heading);
            e.twist = 1'b1;
            e.cmd.vx = 17'(speed_scale(vx));
            e.cmd.vy = 17'(speed_scale(vy));
            e.cmd.vz = 17'(speed_scale(vz << gvcm_pkg::XBITS));
            e.cmd.yaw = 16'(speed_scale(vw << gvcm_pkg::XBITS));
        end
        prev_btn = r.buttons;
        return 1'b1;
    endfunction

    // Axis values: extremes, values on the edge of the deadzone, or anything.
    function automatic logic [15:0] pick_axis();
        int m;
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            1:
            begin
                m = dz_reg + int'($urandom_range(0, 4)) - 2;
                if (m < 0)
                    m = 0;
                if (m > 32767)
                    m = 32767;
                return ($urandom_range(0, 1) != 0) ? 16'(-m) : 16'(m);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly flying states and held buttons, so that edges and rotation get exercised.
    function automatic report_t pick_report(output bit nav);
        report_t r;
        nav = ($urandom_range(0, 5) == 0);
        r.pad = '0;
        r.ax = pick_axis();
        r.ay = pick_axis();
        r.aup = pick_axis();
        r.adown = pick_axis();
        r.ayaw = pick_axis();
        case ($urandom_range(0, 4))
            0, 1:    r.buttons = held_buttons;
            2:       r.buttons = '0;
            3:       r.buttons = 6'($urandom);
            default: r.buttons = held_buttons ^ (6'd1 << $urandom_range(0, 5));
        endcase
        if ($urandom_range(0, 3) != 0)
            r.fstate = 4'($urandom_range(3, 8));
        else
            r.fstate = 4'($urandom_range(0, 15));
        r.heading = 16'($urandom);
        if (!nav)
            held_buttons = r.buttons;
        return r;
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Offer one report in bursts with random gaps, and record what it should cause.
    task automatic offer_report(input bit nav, input report_t r, input bit known,
                                input twist_exp_t want);
        twist_exp_t pred;
        bit         emits;
        @(negedge clk);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 16);
        end
        s_tvalid = 1'b1;
        s_tdata = r;
        s_tuser = nav;
        burst_left--;
        do
            @(posedge clk);
        while (!s_tready);
        emits = map_report(nav, r, pred);
        if (emits)
            twist_pending.push_back(known ? want : pred);
    endtask

    // Stop offering and wait until every command has come out and the block is quiet.
    task automatic settle_outputs();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (twist_pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_deadzone(input int v);
        settle_outputs();
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = gvcm_pkg::DZ_W'(v);
        @(negedge clk);
        cfg_wr_en = 1'b0;
        dz_reg = v;
    endtask

    // Receiver: changes its stall pattern every so often, and serves long hold-offs.
    initial
    begin
        int mode;
        int stretch;
        int hold_left;
        int tick;
        mode = 0;
        stretch = 0;
        hold_left = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode = $urandom_range(0, 3);
                    stretch = $urandom_range(20, 200);
                end
                stretch--;
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = 1'($urandom_range(0, 1));
                    2:       m_tready = ((tick % 7) < 2);
                    default: m_tready = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Compare each command transfer with the oldest expectation.
    always @(posedge clk)
    begin
        twist_exp_t got;
        twist_exp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.twist = m_tuser;
            got.cmd = m_tdata;
            if (twist_pending.size() == 0)
            begin
                $error("command transfer with nothing expected: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = twist_pending.pop_front();
                check_field("twist_valid", want.twist, got.twist);
                check_field("vel_x", $signed(want.cmd.vx), $signed(got.cmd.vx));
                check_field("vel_y", $signed(want.cmd.vy), $signed(got.cmd.vy));
                check_field("vel_z", $signed(want.cmd.vz), $signed(got.cmd.vz));
                check_field("yaw_rate", $signed(want.cmd.yaw), $signed(got.cmd.yaw));
                check_field("reset_request", want.cmd.req.reset, got.cmd.req.reset);
                check_field("takeoff_request", want.cmd.req.takeoff, got.cmd.req.takeoff);
                check_field("land_request", want.cmd.req.land, got.cmd.req.land);
                check_field("trim_request", want.cmd.req.trim, got.cmd.req.trim);
                check_field("camera_toggle_request", want.cmd.req.camera,
                            got.cmd.req.camera);
            end
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $error("no transfer for %0d cycles", IDLE_LIMIT);
                $display("FAIL gamepad_velocity_command_mapper_top");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t   dir_tab [0:DIR_ROWS-1];
        int         phase_dz [0:PHASES-1];
        report_t    rep;
        twist_exp_t want;
        bit         nav;
        int         i;
        int         ph;
        int         k;

        speed = int'(gvcm_pkg::SPEED_RESET);
        rel_mode = 1'b0;
        prev_btn = '0;
        veh_state = '0;
        veh_heading = '0;
        basis_heading = '0;
        dz_reg = 0;

        // nav, x, y, up, down, yaw, buttons, state, heading,
        // known, twist, vel_x, vel_y, vel_z, yaw_rate, requests
        dir_tab[0]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[1]  = '{0, 32767, -32768, -32768, 32767, 32767, 0, 0, 0,
                        1, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[2]  = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0, REQ_RESET};
        dir_tab[3]  = '{0, 0, 0, 0, 0, 0, 3, 0, 0, 1, 0, 0, 0, 0, 0, REQ_RESET};
        dir_tab[4]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[5]  = '{1, 0, 0, 0, 0, 0, 0, 2, 16384, 0, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[6]  = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0, REQ_TAKEOFF};
        dir_tab[7]  = '{0, 0, 0, 0, 0, 0, 2, 0, 0, 1, 0, 0, 0, 0, 0, REQ_TRIM};
        dir_tab[8]  = '{0, 0, 0, 0, 0, 0, 4, 0, 0, 1, 0, 0, 0, 0, 0, REQ_CAMERA};
        dir_tab[9]  = '{1, 0, 0, 0, 0, 0, 0, 3, 16384, 0, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[10] = '{0, 32767, -32768, -32768, 32767, -32768, 0, 0, 0,
                        1, 1, 16383, -16384, 32767, -16384, REQ_NONE};
        dir_tab[11] = '{0, 0, 0, 0, 0, 0, 2, 0, 0, 1, 1, 0, 0, 0, 0, REQ_NONE};
        dir_tab[12] = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 1, 0, 0, 0, 0, REQ_LAND};
        dir_tab[13] = '{0, 16384, 0, 0, 0, 0, 8, 0, 0, 0, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[14] = '{1, 0, 0, 0, 0, 0, 0, 3, 32768, 0, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[15] = '{0, 16384, 0, 0, 0, 0, 8, 0, 0, 0, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[16] = '{1, 0, 0, 0, 0, 0, 0, 8, 65535, 0, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[17] = '{0, -32768, 32767, 0, 0, 1000, 16, 0, 0,
                        0, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[18] = '{0, 32767, 32767, 4096, -4096, -1, 32, 0, 0,
                        0, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[19] = '{0, -32768, -32768, 32767, -32768, 32767, 0, 0, 0,
                        0, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[20] = '{0, 12345, -23456, 100, -100, 5, 48, 0, 0,
                        0, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[21] = '{1, 0, 0, 0, 0, 0, 0, 9, 0, 0, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[22] = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0, REQ_TAKEOFF};
        dir_tab[23] = '{1, 0, 0, 0, 0, 0, 0, 15, 8192, 0, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[24] = '{0, 0, 0, 0, 0, 0, 2, 0, 0, 1, 0, 0, 0, 0, 0, REQ_TRIM};
        dir_tab[25] = '{1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, REQ_NONE};
        dir_tab[26] = '{0, 0, 0, 0, 0, 0, 63, 0, 0, 1, 0, 0, 0, 0, 0,
                        REQ_RESET | REQ_CAMERA};
        dir_tab[27] = '{1, 0, 0, 0, 0, 0, 0, 4, 12345, 0, 0, 0, 0, 0, 0, REQ_NONE};

        phase_dz = '{0, 65536, 1, 65535, $urandom_range(0, 4096),
                     $urandom_range(0, 65536), 32768};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: walk the table.
        for (i = 0; i < DIR_ROWS; i++)
        begin
            rep = '0;
            rep.ax = 16'(dir_tab[i].ax);
            rep.ay = 16'(dir_tab[i].ay);
            rep.aup = 16'(dir_tab[i].aup);
            rep.adown = 16'(dir_tab[i].adown);
            rep.ayaw = 16'(dir_tab[i].ayaw);
            rep.buttons = 6'(dir_tab[i].btn);
            rep.fstate = 4'(dir_tab[i].fst);
            rep.heading = 16'(dir_tab[i].hdg);
            want.twist = dir_tab[i].twist;
            want.cmd.vx = 17'(dir_tab[i].vx);
            want.cmd.vy = 17'(dir_tab[i].vy);
            want.cmd.vz = 17'(dir_tab[i].vz);
            want.cmd.yaw = 16'(dir_tab[i].yaw);
            want.cmd.req = gvcm_pkg::req_t'(dir_tab[i].req);
            offer_report(dir_tab[i].nav, rep, dir_tab[i].known, want);
        end
        held_buttons = prev_btn;

        // Random part, one deadzone setting per phase; two phases include a long stall.
        for (ph = 0; ph < PHASES; ph++)
        begin
            write_deadzone(phase_dz[ph]);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if ((ph == 1 || ph == 4) && k == 20)
                    hold_req = 1'b1;
                rep = pick_report(nav);
                offer_report(nav, rep, 1'b0, '0);
            end
        end

        settle_outputs();
        if (fail_count == 0 && twist_pending.size() == 0)
            $display("PASS gamepad_velocity_command_mapper_top");
        else
            $display("FAIL gamepad_velocity_command_mapper_top");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/gvcm_pkg.sv
hw/rtl/gamepad_velocity_command_mapper_top.sv
tb/testbench.sv
